@@ rtl/sfm_pkg.sv @@
package sfm_pkg;

  // Search limits.
  localparam int unsigned MaxNeedle   = 32;
  localparam int unsigned MaxHaystack = 65536;

  // Field and state widths.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned OffW    = 16;
  localparam int unsigned SeenW   = $clog2(MaxHaystack + 1);
  localparam int unsigned LenRegW = 6;
  localparam int unsigned LenW    = $clog2(MaxNeedle + 1);
  localparam int unsigned IdxW    = $clog2(MaxNeedle);

  // Configuration port layout.
  localparam int unsigned NeedleRegs = 4;
  localparam int unsigned RegW       = 64;
  localparam int unsigned AddrW      = 6;
  localparam int unsigned RegIdxW    = 3;
  localparam int unsigned AddrLsb    = 3;

  typedef enum logic [RegIdxW-1:0] {
    RegNeedleA = 3'd0,
    RegNeedleB = 3'd1,
    RegNeedleC = 3'd2,
    RegNeedleD = 3'd3,
    RegLength  = 3'd4
  } reg_idx_e;

  // Needle bytes (byte 0 lowest) and the raw length register.
  typedef struct packed {
    logic [NeedleRegs*RegW-1:0] needle;
    logic [LenRegW-1:0]         length;
  } cfg_t;

  // Result of one processed haystack byte.
  typedef struct packed {
    logic            valid;
    logic            found;
    logic [OffW-1:0] offset;
  } result_t;

endpackage

@@ rtl/substring_first_match.sv @@
// Channel   Dir  Payload                                 Transaction when
// s_axis    in   tdata[7:0] haystack_byte, tlast final  tvalid && tready
// m_axis    out  tdata[15:0] match_offset, tuser found   tvalid && tready
// apb       in   needle A..D at 0x00..0x18, length 0x20  psel && penable && pwrite
//
// One haystack byte per cycle is sustained unless m_axis stalls; the
// window compare of all needle positions is done in a single pass after the
// input register, and its result is held in the result register on m_axis.
// Reset clears the needle, length, window, byte count and match flag.
// A stalled m_axis holds its result while one more byte waits in the
// input register; s_axis stalls only when both registers are full.
module substring_first_match import sfm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [ByteW-1:0] s_axis_tdata_i,   // [7:0] haystack_byte
  input  logic             s_axis_tlast_i,   // final_byte
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [OffW-1:0]  m_axis_tdata_o,   // [15:0] match_offset
  output logic             m_axis_tuser_o,   // [0] found
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [RegW-1:0]  pwdata,
  output logic [RegW-1:0]  prdata,
  output logic             pready
);

  cfg_t            cfg;
  result_t         res;
  logic            stg_valid_q, stg_valid_d;
  logic [ByteW-1:0] stg_byte_q;
  logic            stg_last_q;
  logic            stg_fire, in_acc;
  logic            out_valid_q, out_valid_d;
  logic            out_found_q;
  logic [OffW-1:0] out_off_q;

  sfm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sfm_search u_search (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (stg_fire),
    .byte_i (stg_byte_q),
    .last_i (stg_last_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // The staged byte is processed when the result register is free.
  assign stg_fire        = stg_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !stg_valid_q || stg_fire;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // Input register.
  assign stg_valid_d = in_acc || (stg_valid_q && !stg_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      stg_byte_q <= s_axis_tdata_i;
      stg_last_q <= s_axis_tlast_i;
    end
  end

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (stg_fire) begin
      out_valid_d = res.valid;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_fire && res.valid) begin
      out_found_q <= res.found;
      out_off_q   <= res.offset;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_off_q;
  assign m_axis_tuser_o  = out_found_q;

endmodule

@@ rtl/sfm_cfg.sv @@
module sfm_cfg import sfm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [RegW-1:0]  pwdata,
  output logic [RegW-1:0]  prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  logic [NeedleRegs-1:0][RegW-1:0] needle_q, needle_d;
  logic [LenRegW-1:0]              length_q, length_d;
  logic                            wr_en;
  reg_idx_e                        idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[AddrW-1:AddrLsb]);

  // Register write decode; addresses past the list are ignored.
  always_comb begin
    needle_d = needle_q;
    length_d = length_q;
    if (wr_en) begin
      unique case (idx)
        RegNeedleA: needle_d[0] = pwdata;
        RegNeedleB: needle_d[1] = pwdata;
        RegNeedleC: needle_d[2] = pwdata;
        RegNeedleD: needle_d[3] = pwdata;
        RegLength:  length_d    = pwdata[LenRegW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needle_q <= '0;
      length_q <= '0;
    end else begin
      needle_q <= needle_d;
      length_q <= length_d;
    end
  end

  // Read back.
  always_comb begin
    prdata = '0;
    unique case (idx)
      RegNeedleA: prdata = needle_q[0];
      RegNeedleB: prdata = needle_q[1];
      RegNeedleC: prdata = needle_q[2];
      RegNeedleD: prdata = needle_q[3];
      RegLength:  prdata = RegW'(length_q);
      default:    prdata = '0;
    endcase
  end

  assign cfg_o.needle = needle_q;
  assign cfg_o.length = length_q;

endmodule

@@ rtl/sfm_search.sv @@
module sfm_search import sfm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [ByteW-1:0] byte_i,
  input  logic             last_i,
  input  cfg_t             cfg_i,
  output result_t          res_o
);

  logic [MaxNeedle-1:0][ByteW-1:0] win_q, win_d, win_new;
  logic [SeenW-1:0]                seen_q, seen_d, seen_inc;
  logic                            reported_q, reported_d;
  logic [LenW-1:0]                 len_eff;
  logic [MaxNeedle-1:0]            hit;
  logic                            enough;
  result_t                         res;

  // Lengths above the needle store are clamped.
  assign len_eff = (cfg_i.length > LenRegW'(MaxNeedle)) ? LenW'(MaxNeedle)
                                                        : LenW'(cfg_i.length);

  // Window after shifting in the new byte; entry 0 is the newest.
  always_comb begin
    win_new[0] = byte_i;
    for (int k = 1; k < MaxNeedle; k++) begin
      win_new[k] = win_q[k-1];
    end
  end

  // Window entry k lines up with needle byte len-1-k; entries past the
  // needle length always agree.
  always_comb begin
    logic [IdxW-1:0] ref_idx;
    for (int k = 0; k < MaxNeedle; k++) begin
      ref_idx = IdxW'(len_eff - LenW'(1) - LenW'(k));
      hit[k]  = (LenW'(k) >= len_eff) ||
                (win_new[k] == cfg_i.needle[ref_idx*ByteW +: ByteW]);
    end
  end

  assign seen_inc = seen_q + SeenW'(1);
  assign enough   = (seen_inc >= SeenW'(len_eff));

  // Per-byte decision and next state.
  always_comb begin
    win_d      = win_q;
    seen_d     = seen_q;
    reported_d = reported_q;
    res        = '0;
    if (!reported_q) begin
      if (len_eff == '0) begin
        // An empty needle matches at the start of the haystack.
        if (seen_q == '0) begin
          res.valid  = 1'b1;
          res.found  = 1'b1;
          reported_d = 1'b1;
        end
      end else if (seen_q < SeenW'(MaxHaystack)) begin
        win_d  = win_new;
        seen_d = seen_inc;
        if (enough && (&hit)) begin
          res.valid  = 1'b1;
          res.found  = 1'b1;
          res.offset = OffW'(seen_inc - SeenW'(len_eff));
          reported_d = 1'b1;
        end
      end
      if (last_i && !res.valid) begin
        res.valid = 1'b1;
      end
    end
    // The last byte readies the state for the next haystack.
    if (last_i) begin
      win_d      = '0;
      seen_d     = '0;
      reported_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q      <= '0;
      seen_q     <= '0;
      reported_q <= 1'b0;
    end else if (fire_i) begin
      win_q      <= win_d;
      seen_q     <= seen_d;
      reported_q <= reported_d;
    end
  end

  assign res_o = res;

  // Once a match is reported, bytes before the last one yield nothing.
  a_quiet_after_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && reported_q && !last_i |-> !res.valid)
    else $error("result produced after a reported match");

  // The last byte leaves a cleared search state.
  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && last_i |=> (seen_q == '0) && !reported_q)
    else $error("state not cleared after last byte");

  // The byte count never passes its saturation point.
  a_seen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= SeenW'(MaxHaystack))
    else $error("byte count beyond saturation");

  // A not-found result always carries offset zero.
  a_miss_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res.valid && !res.found |-> res.offset == '0)
    else $error("not-found result with nonzero offset");

endmodule
